// ----- rtl/bgzf_block_header_parser_macros.svh -----
// Assertion helpers for the BGZF header parser
`ifndef BGZF_BLOCK_HEADER_PARSER_MACROS_SVH
`define BGZF_BLOCK_HEADER_PARSER_MACROS_SVH

`ifndef SYNTHESIS
`define BGZF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define BGZF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BGZF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define BGZF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- rtl/bgzf_pkg.sv -----
package bgzf_pkg;

  localparam int DATA_W  = 8;
  localparam int SIZE_W  = 17;
  localparam int PAY_W   = 16;
  localparam int LEN_W   = 16;
  localparam int STAT_W  = 2;
  localparam int PHASE_W = 3;
  localparam int FIX_W   = 4;

  typedef logic [DATA_W-1:0]  byte_t;
  typedef logic [SIZE_W-1:0]  size_t;
  typedef logic [PAY_W-1:0]   pay_t;
  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [STAT_W-1:0]  status_t;
  typedef logic [PHASE_W-1:0] phase_t;
  typedef logic [FIX_W-1:0]   fix_t;

  localparam phase_t PH_IDLE    = 3'd0;
  localparam phase_t PH_FIXED   = 3'd1;
  localparam phase_t PH_SUBHDR  = 3'd2;
  localparam phase_t PH_SUBDATA = 3'd3;
  localparam phase_t PH_SKIP    = 3'd4;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_BAD_MAGIC = 2'd1;
  localparam status_t ST_SHORT_XL  = 2'd2;
  localparam status_t ST_BAD_SIZE  = 2'd3;

  localparam byte_t MAGIC_0 = 8'd31;
  localparam byte_t MAGIC_1 = 8'h8b;
  localparam byte_t MAGIC_2 = 8'd8;
  localparam byte_t MAGIC_3 = 8'd4;

  localparam fix_t FIX_XLEN_LO = 4'd10;
  localparam fix_t FIX_XLEN_HI = 4'd11;

  localparam len_t  BC_TAG       = 16'h4243;
  localparam len_t  BC_LEN       = 16'd2;
  localparam len_t  MIN_XLEN     = 16'd6;
  localparam len_t  SUBHDR_BYTES = 16'd4;
  localparam size_t FIXED_HDR    = 17'd12;
  localparam size_t FOOTER_BYTES = 17'd8;

endpackage

// ----- rtl/bgzf_in_if.sv -----
interface bgzf_in_if;
  import bgzf_pkg::*;

  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  block_start;

  modport source (output valid, output data_byte, output block_start, input ready);
  modport sink   (input valid, input data_byte, input block_start, output ready);
endinterface

// ----- rtl/bgzf_out_if.sv -----
interface bgzf_out_if;
  import bgzf_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  size_t   blk_size;
  size_t   header_size;
  pay_t    payload_size;

  modport source (output valid, output status, output blk_size, output header_size,
                  output payload_size, input ready);
  modport sink   (input valid, input status, input blk_size, input header_size,
                  input payload_size, output ready);
endinterface

// ----- rtl/bgzf_block_header_parser.sv -----
// Channel   Dir  Beat payload                                        Handshake
// in_bus    in   data_byte[7:0], block_start                         valid/ready
// out_bus   out  status, blk_size, header_size, payload_size         valid/ready
//
// One header byte per cycle, unless an untaken status stalls it; the beat that ends the
// header gives a status by way of the input register, then the result register.
// Reset (rst_n low, synchronous) leaves the parser idle, waiting for block_start.
// A byte stalls in the input register only while the result register holds an
// untaken status; the input side keeps accepting while out_ready is high.
module bgzf_block_header_parser (
  input  logic               clk,
  input  logic               rst_n,
  bgzf_in_if.sink            in_bus,
  bgzf_out_if.source         out_bus
);
  import bgzf_pkg::*;
`include "bgzf_block_header_parser_macros.svh"

  logic    in_vld_r;
  byte_t   in_byte_r;
  logic    in_start_r;

  phase_t  phase_r, phase_nxt;
  fix_t    fixed_count_r, fixed_count_nxt;
  len_t    extra_length_r, extra_length_nxt;
  len_t    extra_left_r, extra_left_nxt;
  logic [1:0] sub_idx_r, sub_idx_nxt;
  len_t    sub_tag_r, sub_tag_nxt;
  len_t    sub_length_r, sub_length_nxt;
  len_t    sub_data_left_r, sub_data_left_nxt;
  size_t   found_size_r, found_size_nxt;

  logic    out_vld_r;
  status_t out_status_r;
  size_t   out_bsize_r;
  size_t   out_hsize_r;
  pay_t    out_psize_r;

  logic    emit;
  status_t emit_status;
  size_t   emit_bsize;
  size_t   emit_hsize;
  pay_t    emit_psize;

  logic    slot_free;
  logic    fire;

  assign slot_free    = !out_vld_r || out_bus.ready;
  assign fire         = in_vld_r && slot_free;
  assign in_bus.ready = !in_vld_r || slot_free;

  always_comb begin
    phase_t ph;
    fix_t   fc;
    len_t   xl;
    len_t   xleft;
    len_t   tag;
    len_t   slen;
    len_t   sdl;
    len_t   full_len;
    size_t  fs;
    size_t  hs;
    logic [SIZE_W:0] lim;
    logic [1:0] k;
    logic   bad;
    logic   bc_ok;
    logic   go_next;

    ph       = phase_r;
    fc       = fixed_count_r;
    xl       = extra_length_r;
    xleft    = extra_left_r;
    k        = sub_idx_r;
    tag      = sub_tag_r;
    slen     = sub_length_r;
    sdl      = sub_data_left_r;
    fs       = found_size_r;
    hs       = '0;
    lim      = '0;
    full_len = '0;
    bad      = 1'b0;
    bc_ok    = 1'b0;
    go_next  = 1'b0;

    emit        = 1'b0;
    emit_status = ST_OK;
    emit_bsize  = '0;
    emit_hsize  = '0;
    emit_psize  = '0;

    if (in_start_r) begin
      ph    = PH_FIXED;
      fc    = '0;
      xl    = '0;
      xleft = '0;
      k     = '0;
      tag   = '0;
      slen  = '0;
      sdl   = '0;
      fs    = '0;
    end

    if (ph == PH_FIXED) begin
      unique case (fc)
        4'd0:    bad = in_byte_r != MAGIC_0;
        4'd1:    bad = in_byte_r != MAGIC_1;
        4'd2:    bad = in_byte_r != MAGIC_2;
        4'd3:    bad = in_byte_r != MAGIC_3;
        default: bad = 1'b0;
      endcase
      if (bad) begin
        emit        = 1'b1;
        emit_status = ST_BAD_MAGIC;
        ph          = PH_IDLE;
      end else begin
        if (fc == FIX_XLEN_LO) xl = {8'd0, in_byte_r};
        if (fc == FIX_XLEN_HI) xl = {in_byte_r, xl[7:0]};
        if (fc == FIX_XLEN_HI) begin
          if (xl < MIN_XLEN) begin
            emit        = 1'b1;
            emit_status = ST_SHORT_XL;
            emit_hsize  = FIXED_HDR + {1'b0, xl};
            ph          = PH_IDLE;
          end else begin
            xleft = xl;
            k     = '0;
            ph    = (xleft >= SUBHDR_BYTES) ? PH_SUBHDR : PH_SKIP;
          end
        end
        fc = fc + 4'd1;
      end
    end else if (ph != PH_IDLE) begin
      if (xleft != '0) xleft = xleft - 16'd1;
      case (ph)
        PH_SUBHDR: begin
          case (k)
            2'd0: tag = {in_byte_r, 8'd0};
            2'd1: tag = {tag[15:8], in_byte_r};
            2'd2: slen = {8'd0, in_byte_r};
            default: begin
              full_len = {in_byte_r, slen[7:0]};
              bc_ok    = (tag == BC_TAG) && (full_len == BC_LEN) && (full_len <= xleft);
              sdl      = (full_len < xleft) ? full_len : xleft;
              slen     = bc_ok ? BC_LEN : '0;
              if (sdl == '0) go_next = 1'b1;
              else ph = PH_SUBDATA;
            end
          endcase
          k = k + 2'd1;
        end
        PH_SUBDATA: begin
          if (sdl != '0) sdl = sdl - 16'd1;
          if (slen == BC_LEN) begin
            if (sdl == 16'd1) tag = {8'd0, in_byte_r};
            else if (sdl == '0) fs = {1'b0, in_byte_r, tag[7:0]} + 17'd1;
          end
          if (sdl == '0) go_next = 1'b1;
        end
        default: ;
      endcase
      if (go_next) begin
        k  = '0;
        ph = (xleft >= SUBHDR_BYTES) ? PH_SUBHDR : PH_SKIP;
      end
      if (xleft == '0) begin
        hs         = FIXED_HDR + {1'b0, xl};
        lim        = {1'b0, hs} + {1'b0, FOOTER_BYTES};
        emit       = 1'b1;
        emit_bsize = fs;
        emit_hsize = hs;
        ph         = PH_IDLE;
        if ({1'b0, fs} <= lim) begin
          emit_status = ST_BAD_SIZE;
        end else begin
          emit_status = ST_OK;
          emit_psize  = PAY_W'(fs - hs - FOOTER_BYTES);
        end
      end
    end

    phase_nxt         = ph;
    fixed_count_nxt   = fc;
    extra_length_nxt  = xl;
    extra_left_nxt    = xleft;
    sub_idx_nxt       = k;
    sub_tag_nxt       = tag;
    sub_length_nxt    = slen;
    sub_data_left_nxt = sdl;
    found_size_nxt    = fs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_bus.ready) begin
      in_vld_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      in_byte_r  <= in_bus.data_byte;
      in_start_r <= in_bus.block_start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      fixed_count_r   <= '0;
      extra_length_r  <= '0;
      extra_left_r    <= '0;
      sub_idx_r       <= '0;
      sub_tag_r       <= '0;
      sub_length_r    <= '0;
      sub_data_left_r <= '0;
      found_size_r    <= '0;
    end else if (fire) begin
      phase_r         <= phase_nxt;
      fixed_count_r   <= fixed_count_nxt;
      extra_length_r  <= extra_length_nxt;
      extra_left_r    <= extra_left_nxt;
      sub_idx_r       <= sub_idx_nxt;
      sub_tag_r       <= sub_tag_nxt;
      sub_length_r    <= sub_length_nxt;
      sub_data_left_r <= sub_data_left_nxt;
      found_size_r    <= found_size_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire && emit) begin
      out_vld_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_status_r <= emit_status;
      out_bsize_r  <= emit_bsize;
      out_hsize_r  <= emit_hsize;
      out_psize_r  <= emit_psize;
    end
  end

  assign out_bus.valid        = out_vld_r;
  assign out_bus.status       = out_status_r;
  assign out_bus.blk_size     = out_bsize_r;
  assign out_bus.header_size  = out_hsize_r;
  assign out_bus.payload_size = out_psize_r;

  // ok status: sizes are consistent
  `BGZF_ASSERT_SAME(a_ok_sizes, clk, rst_n, out_vld_r && out_status_r == ST_OK,
                    {1'b0, out_bsize_r} == {1'b0, out_hsize_r} + {2'b0, out_psize_r}
                      + {1'b0, FOOTER_BYTES},
                    "ok status with inconsistent sizes")
  // bad magic carries no sizes
  `BGZF_ASSERT_SAME(a_magic_zero, clk, rst_n, out_vld_r && out_status_r == ST_BAD_MAGIC,
                    out_bsize_r == '0 && out_hsize_r == '0 && out_psize_r == '0,
                    "bad magic with nonzero sizes")
  // fixed header count never passes the XLEN bytes
  `BGZF_ASSERT_SAME(a_fix_range, clk, rst_n, phase_r == PH_FIXED,
                    fixed_count_r <= FIX_XLEN_HI, "fixed header count overran")
  // data phase always has bytes outstanding
  `BGZF_ASSERT_SAME(a_data_left, clk, rst_n, phase_r == PH_SUBDATA,
                    sub_data_left_r != '0 && extra_left_r != '0,
                    "subfield data phase with nothing left")
  // a status is produced only by an input beat
  `BGZF_ASSERT_NEXT(a_emit_src, clk, rst_n, !out_vld_r && !fire, !out_vld_r,
                    "status appeared without an input beat")

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import bgzf_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int BYTE_TARGET  = 1700;
  localparam int BIG_XLEN     = 600;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    status_t status;
    size_t   blk_size;
    size_t   header_size;
    pay_t    payload_size;
  } hdr_result_t;

  typedef struct packed {
    byte_t       b;
    logic        st;
    bit          typed;
    bit          noise;
    hdr_result_t exp;
  } stim_row_t;

  logic clk;
  logic rst_n;

  bgzf_in_if  in_bus ();
  bgzf_out_if out_bus ();

  bgzf_block_header_parser dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // parser image
  phase_t     pp;
  fix_t       fcnt;
  len_t       xlen;
  len_t       xleft;
  logic [1:0] sidx;
  len_t       stag;
  len_t       slen;
  len_t       sleft;
  size_t      found;

  hdr_result_t pending_status [$];
  stim_row_t   byte_q [$];

  int  send_pct;
  int  recv_pct;
  int  run_phase;
  int  bytes_sent;
  int  fail_cnt;
  int  cycle_cnt;
  bit  hold_off;

  function automatic void hdr_clear();
    pp    = PH_IDLE;
    fcnt  = '0;
    xlen  = '0;
    xleft = '0;
    sidx  = '0;
    stag  = '0;
    slen  = '0;
    sleft = '0;
    found = '0;
  endfunction

  function automatic void next_sub();
    sidx = '0;
    pp   = (xleft >= SUBHDR_BYTES) ? PH_SUBHDR : PH_SKIP;
  endfunction

  function automatic bit header_parse_step(input byte_t b, input logic st,
                                           output hdr_result_t r);
    byte_t      magic [4];
    fix_t       i;
    logic [1:0] k;
    size_t      hs;
    bit         bc_ok;
    magic = '{MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_3};
    r = '0;
    if (st) begin
      hdr_clear();
      pp = PH_FIXED;
    end
    if (pp == PH_IDLE) return 1'b0;
    if (pp == PH_FIXED) begin
      i = fcnt;
      if (i < 4 && b != magic[i[1:0]]) begin
        r  = hdr_result_t'{ST_BAD_MAGIC, 17'd0, 17'd0, 16'd0};
        pp = PH_IDLE;
        return 1'b1;
      end
      if (i == FIX_XLEN_LO) xlen = len_t'(b);
      fcnt = fcnt + 1'b1;
      if (i == FIX_XLEN_HI) begin
        xlen = {b, xlen[7:0]};
        if (xlen < MIN_XLEN) begin
          r  = hdr_result_t'{ST_SHORT_XL, 17'd0, FIXED_HDR + size_t'(xlen), 16'd0};
          pp = PH_IDLE;
          return 1'b1;
        end
        xleft = xlen;
        next_sub();
      end
      return 1'b0;
    end
    if (xleft != 0) xleft = xleft - 1'b1;
    if (pp == PH_SUBHDR) begin
      k = sidx;
      case (k)
        2'd0: stag = {b, 8'h00};
        2'd1: stag[7:0] = b;
        2'd2: slen = len_t'(b);
        default: begin
          slen  = {b, slen[7:0]};
          bc_ok = stag == BC_TAG && slen == BC_LEN && slen <= xleft;
          sleft = (slen < xleft) ? slen : xleft;
          slen  = bc_ok ? BC_LEN : '0;
          if (sleft == 0) next_sub();
          else pp = PH_SUBDATA;
        end
      endcase
      sidx = k + 1'b1;
    end else if (pp == PH_SUBDATA) begin
      if (sleft != 0) sleft = sleft - 1'b1;
      if (slen == BC_LEN) begin
        if (sleft == 1) stag = len_t'(b);
        else if (sleft == 0) found = size_t'({b, stag[7:0]}) + 1'b1;
      end
      if (sleft == 0) next_sub();
    end
    if (xleft == 0) begin
      hs = FIXED_HDR + size_t'(xlen);
      pp = PH_IDLE;
      if (found <= hs + FOOTER_BYTES)
        r = hdr_result_t'{ST_BAD_SIZE, found, hs, 16'd0};
      else
        r = hdr_result_t'{ST_OK, found, hs, pay_t'(found - hs - FOOTER_BYTES)};
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void add_row(input byte_t b, input logic st, input bit typed,
                                  input bit noise, input hdr_result_t exp);
    stim_row_t row;
    row.b     = b;
    row.st    = st;
    row.typed = typed;
    row.noise = noise;
    row.exp   = exp;
    byte_q.push_back(row);
  endfunction

  function automatic void note_fail(input string what, input hdr_result_t e,
                                    input hdr_result_t a);
    fail_cnt++;
    if (fail_cnt <= 10)
      $display("%0t %s: exp st=%0d bs=%0d hs=%0d ps=%0d got st=%0d bs=%0d hs=%0d ps=%0d",
               $realtime, what, e.status, e.blk_size, e.header_size, e.payload_size,
               a.status, a.blk_size, a.header_size, a.payload_size);
  endfunction

  task automatic load_table();
    hdr_result_t none;
    byte_t       fixed_mid [6];
    none      = '0;
    fixed_mid = '{8'h00, 8'hff, 8'h00, 8'hff, 8'h80, 8'h7f};
    add_row(8'hff, 1'b0, 1'b0, 1'b1, none);
    add_row(8'h00, 1'b1, 1'b1, 1'b0, hdr_result_t'{ST_BAD_MAGIC, 17'd0, 17'd0, 16'd0});
    add_row(MAGIC_0, 1'b1, 1'b0, 1'b0, none);
    add_row(MAGIC_1, 1'b0, 1'b0, 1'b0, none);
    add_row(MAGIC_2, 1'b0, 1'b0, 1'b0, none);
    add_row(8'hff, 1'b0, 1'b1, 1'b0, hdr_result_t'{ST_BAD_MAGIC, 17'd0, 17'd0, 16'd0});
    // abandoned by the restart below
    add_row(MAGIC_0, 1'b1, 1'b0, 1'b0, none);
    add_row(MAGIC_1, 1'b0, 1'b0, 1'b0, none);
    add_row(MAGIC_0, 1'b1, 1'b0, 1'b0, none);
    add_row(MAGIC_1, 1'b0, 1'b0, 1'b0, none);
    add_row(MAGIC_2, 1'b0, 1'b0, 1'b0, none);
    add_row(MAGIC_3, 1'b0, 1'b0, 1'b0, none);
    foreach (fixed_mid[j]) add_row(fixed_mid[j], 1'b0, 1'b0, 1'b0, none);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, none);
    add_row(8'h00, 1'b0, 1'b1, 1'b0, hdr_result_t'{ST_SHORT_XL, 17'd0, FIXED_HDR, 16'd0});
  endtask

  task automatic gen_header(input bit big);
    byte_t       hb [$];
    int unsigned xl, rem, len, n, pick, kind, p, j, hs;
    logic [15:0] tag, bsize;
    bit          bc2;
    hdr_result_t none;
    none = '0;
    kind = big ? 99 : $urandom_range(0, 99);
    if (kind < 5 && pp == PH_IDLE) begin
      repeat ($urandom_range(1, 3)) add_row(byte_t'($urandom), 1'b0, 1'b0, 1'b1, none);
      return;
    end
    hb = {MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_3};
    repeat (6) hb.push_back(byte_t'($urandom));
    pick = $urandom_range(0, 99);
    if (big) xl = BIG_XLEN;
    else if (pick < 10) xl = $urandom_range(0, 5);
    else if (pick < 80) xl = $urandom_range(6, 40);
    else xl = $urandom_range(41, 300);
    hb.push_back(xl[7:0]);
    hb.push_back(xl[15:8]);
    hs  = 12 + xl;
    rem = (xl >= MIN_XLEN) ? xl : 0;
    while (rem > 0) begin
      if (rem < SUBHDR_BYTES) begin
        repeat (rem) hb.push_back(byte_t'($urandom));
        rem = 0;
      end else begin
        rem  = rem - SUBHDR_BYTES;
        pick = $urandom_range(0, 99);
        tag  = (pick < 50) ? BC_TAG : (pick < 60) ? {8'h42, 8'($urandom)} : 16'($urandom);
        pick = $urandom_range(0, 99);
        if (tag == BC_TAG && pick < 70) len = BC_LEN;
        else begin
          pick = $urandom_range(0, 99);
          if (pick < 75) len = $urandom_range(0, rem);
          else if (pick < 90) len = rem + $urandom_range(0, 3);
          else len = 16'($urandom);
        end
        pick = $urandom_range(0, 99);
        if (pick < 25) bsize = 16'(hs + 6 + $urandom_range(0, 2));
        else if (pick < 35) bsize = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        else bsize = 16'($urandom);
        hb.push_back(tag[15:8]);
        hb.push_back(tag[7:0]);
        hb.push_back(len[7:0]);
        hb.push_back(len[15:8]);
        n   = (len < rem) ? len : rem;
        bc2 = tag == BC_TAG && len == BC_LEN;
        for (j = 0; j < n; j++)
          hb.push_back((bc2 && j == 0) ? bsize[7:0] :
                       (bc2 && j == 1) ? bsize[15:8] : byte_t'($urandom));
        rem = rem - n;
      end
    end
    if (kind < 10) begin
      p     = $urandom_range(0, 3);
      hb[p] = hb[p] ^ byte_t'($urandom_range(1, 255));
      while (hb.size() > p + 1) void'(hb.pop_back());
    end else if (kind < 22) begin
      p = $urandom_range(1, hb.size() - 1);
      while (hb.size() > p) void'(hb.pop_back());
    end
    foreach (hb[i]) add_row(hb[i], i == 0, 1'b0, 1'b0, none);
  endtask

  task automatic send_beat(input stim_row_t row);
    hdr_result_t r;
    bit          got;
    while ($urandom_range(0, 99) < send_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.data_byte   <= row.b;
    in_bus.block_start <= row.st;
    do @(posedge clk); while (!in_bus.ready);
    got = header_parse_step(row.b, row.st, r);
    if (row.typed) pending_status.push_back(row.exp);
    else if (got) pending_status.push_back(r);
    if (!row.noise) bytes_sent++;
    @(negedge clk);
  endtask

  task automatic drain_bytes();
    while (byte_q.size() != 0) send_beat(byte_q.pop_front());
  endtask

  always @(negedge clk)
    out_bus.ready <= rst_n && !hold_off && ($urandom_range(0, 99) >= recv_pct);

  always @(posedge clk) begin
    hdr_result_t act;
    hdr_result_t e;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      act = {out_bus.status, out_bus.blk_size, out_bus.header_size, out_bus.payload_size};
      if (pending_status.size() == 0) note_fail("unexpected status beat", '0, act);
      else begin
        e = pending_status.pop_front();
        if (act.status !== e.status || act.blk_size !== e.blk_size ||
            act.header_size !== e.header_size || act.payload_size !== e.payload_size)
          note_fail("status mismatch", e, act);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("bgzf_block_header_parser verification failed");
      $finish;
    end
  end

  // long receiver hold-off so the input side backs up
  initial begin
    hold_off = 1'b0;
    wait (run_phase == 2);
    repeat (50) @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.data_byte   = '0;
    in_bus.block_start = 1'b0;
    out_bus.ready      = 1'b0;
    send_pct           = 31;
    recv_pct           = 50;
    run_phase          = -1;
    bytes_sent         = 0;
    fail_cnt           = 0;
    cycle_cnt          = 0;
    hdr_clear();
    load_table();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    drain_bytes();
    for (int ph = 0; ph < 3; ph++) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
      run_phase = ph;
      send_pct  = (ph == 0) ? 31 : (ph == 1) ? 50 : 0;
      recv_pct  = (ph == 0) ? 50 : (ph == 1) ? 31 : 0;
      @(negedge clk);
      while (bytes_sent < (BYTE_TARGET - BIG_XLEN - 12) * (ph + 1) / 3) begin
        gen_header(1'b0);
        drain_bytes();
      end
    end
    gen_header(1'b1);
    drain_bytes();
    in_bus.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && pending_status.size() == 0)
      $display("bgzf_block_header_parser verification clean");
    else
      $display("bgzf_block_header_parser verification failed");
    $finish;
  end

endmodule
